/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands shared by the RTL; compiled out when
// NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define TPS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define TPS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define TPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define TPS_ASSERT(label, clk, rst, prop)
`define TPS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define TPS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* src/tps_pkg.sv */
// ----------------------------------------------------------------------------
// tps_pkg
// Sizes, codes and shared types of the timer pool scheduler.
// ----------------------------------------------------------------------------
package tps_pkg;

   localparam int TIMER_SLOTS = 32;
   localparam int TIME_BITS   = 32;
   localparam int REPEAT_BITS = 16;

   localparam int IDX_BITS    = $clog2(TIMER_SLOTS);

   // word field widths
   localparam int ACTION_BITS   = 2;
   localparam int INTERVAL_BITS = 32;
   localparam int COUNT_BITS    = 16;
   localparam int HANDLE_BITS   = 5;
   localparam int KIND_BITS     = 2;
   localparam int ID_BITS       = 5;
   localparam int NOW_BITS      = 32;
   localparam int PERIOD_BITS   = 32;

   localparam int CALC_BITS = (TIME_BITS > PERIOD_BITS) ? TIME_BITS : PERIOD_BITS;
   localparam int HCMP_BITS = (IDX_BITS > HANDLE_BITS) ? IDX_BITS : HANDLE_BITS;

   localparam logic [ACTION_BITS-1:0] ACT_TICK   = 2'd0;
   localparam logic [ACTION_BITS-1:0] ACT_ADD    = 2'd1;
   localparam logic [ACTION_BITS-1:0] ACT_CANCEL = 2'd2;

   localparam logic [KIND_BITS-1:0] KIND_ADDED     = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_FIRED     = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_IMMEDIATE = 2'd2;
   localparam logic [KIND_BITS-1:0] KIND_FULL      = 2'd3;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_TICK  = 5'b00010,
      ST_ADD   = 5'b00100,
      ST_FLUSH = 5'b01000,
      ST_IMM   = 5'b10000
   } state_type;

   // broadcast from the sequencer to every cell
   typedef struct packed {
      logic                   start;
      logic                   step;
      logic                   tick_mode;
      logic                   add_mode;
      logic                   cancel;
      logic [HANDLE_BITS-1:0] handle;
      logic [TIME_BITS-1:0]   time_now;
      logic [TIME_BITS-1:0]   add_deadline;
      logic [PERIOD_BITS-1:0] add_period;
      logic [REPEAT_BITS-1:0] add_repeats;
   } cell_ctrl_type;

   // what one cell reports back
   typedef struct packed {
      logic tok;
      logic fire;
      logic take;
   } cell_stat_type;

endpackage

/* src/tps_if.sv */
// ----------------------------------------------------------------------------
// tps channel interfaces
// Valid/ready channels for request words and response words.
// ----------------------------------------------------------------------------
interface tps_req_if;
   logic                             valid;
   logic                             ready;
   logic [tps_pkg::ACTION_BITS-1:0]   action;
   logic [tps_pkg::INTERVAL_BITS-1:0] interval;
   logic [tps_pkg::COUNT_BITS-1:0]    repeat_count;
   logic [tps_pkg::HANDLE_BITS-1:0]   handle;

   modport source (output valid, action, interval, repeat_count, handle, input ready);
   modport sink   (input valid, action, interval, repeat_count, handle, output ready);
endinterface

interface tps_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tps_pkg::KIND_BITS-1:0]  kind;
   logic [tps_pkg::ID_BITS-1:0]    timer_id;
   logic [tps_pkg::NOW_BITS-1:0]   now;
   logic                          last;

   modport source (output valid, kind, timer_id, now, last, input ready);
   modport sink   (input valid, kind, timer_id, now, last, output ready);
endinterface

/* src/tps_cell.sv */
// ----------------------------------------------------------------------------
// tps_cell
// One timer entry of the chain: holds its deadline, period and repeats and
// passes the scan token to its right-hand neighbour.
// ----------------------------------------------------------------------------
module tps_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [tps_pkg::IDX_BITS-1:0]  cell_index,
   input  tps_pkg::cell_ctrl_type        ctrl,
   input  logic                          tok_left,
   output logic                          tok_right,
   output tps_pkg::cell_stat_type        stat
);

   logic                             tok_ff, tok_in;
   logic                             valid_ff, valid_in;
   logic [tps_pkg::TIME_BITS-1:0]    deadline_ff, deadline_in;
   logic [tps_pkg::PERIOD_BITS-1:0]  period_ff, period_in;
   logic [tps_pkg::REPEAT_BITS-1:0]  repeats_ff, repeats_in;
   logic [tps_pkg::CALC_BITS-1:0]    rearm_sum;
   logic                             fire, take, cancel_hit;

   assign fire = tok_ff & ctrl.tick_mode & valid_ff & (deadline_ff == ctrl.time_now);
   assign take = tok_ff & ctrl.add_mode & ~valid_ff;
   assign cancel_hit = ctrl.cancel &
      (tps_pkg::HCMP_BITS'(ctrl.handle) == tps_pkg::HCMP_BITS'(cell_index));
   assign rearm_sum = tps_pkg::CALC_BITS'(ctrl.time_now) + tps_pkg::CALC_BITS'(period_ff);

   // a free cell claimed by an add swallows the token
   assign tok_right = tok_ff & ~take;
   assign stat = '{tok: tok_ff, fire: fire, take: take};

   always_comb begin
      tok_in      = (ctrl.step | ctrl.start) ? tok_left : tok_ff;
      valid_in    = valid_ff;
      deadline_in = deadline_ff;
      period_in   = period_ff;
      repeats_in  = repeats_ff;
      if (cancel_hit) begin
         valid_in = 1'b0;
      end else if (ctrl.step && fire) begin
         if (repeats_ff == tps_pkg::REPEAT_BITS'(1)) begin
            valid_in = 1'b0;
         end else begin
            deadline_in = rearm_sum[tps_pkg::TIME_BITS-1:0];
            if (repeats_ff != '0) begin
               repeats_in = repeats_ff - tps_pkg::REPEAT_BITS'(1);
            end
         end
      end else if (ctrl.step && take) begin
         valid_in    = 1'b1;
         deadline_in = ctrl.add_deadline;
         period_in   = ctrl.add_period;
         repeats_in  = ctrl.add_repeats;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         tok_ff   <= tok_in;
         valid_ff <= valid_in;
      end
      deadline_ff <= deadline_in;
      period_ff   <= period_in;
      repeats_ff  <= repeats_in;
   end

endmodule

/* src/tps_ctrl.sv */
// ----------------------------------------------------------------------------
// tps_ctrl
// Sequencer: takes request words, walks the token down the cell chain,
// holds the time counter and drives the response register.
// ----------------------------------------------------------------------------
module tps_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   tps_req_if.sink                req,
   tps_rsp_if.source              rsp,
   input  logic                   any_fire,
   input  logic                   any_take,
   output tps_pkg::cell_ctrl_type cell_ctrl,
   output logic                   busy
);

   localparam logic [tps_pkg::IDX_BITS-1:0] IDX_LAST =
      tps_pkg::IDX_BITS'(tps_pkg::TIMER_SLOTS - 1);

   tps_pkg::state_type               state_ff, state_in;
   logic [tps_pkg::IDX_BITS-1:0]     idx_ff, idx_in;
   logic [tps_pkg::TIME_BITS-1:0]    time_ff, time_in;
   logic                             held_valid_ff, held_valid_in;
   logic [tps_pkg::IDX_BITS-1:0]     held_id_ff, held_id_in;
   logic [tps_pkg::TIME_BITS-1:0]    add_deadline_ff;
   logic [tps_pkg::PERIOD_BITS-1:0]  add_period_ff;
   logic [tps_pkg::REPEAT_BITS-1:0]  add_repeats_ff;
   logic                             rsp_valid_ff;
   logic [tps_pkg::KIND_BITS-1:0]    rsp_kind_ff;
   logic [tps_pkg::ID_BITS-1:0]      rsp_id_ff;
   logic [tps_pkg::NOW_BITS-1:0]     rsp_now_ff;
   logic                             rsp_last_ff;
   logic [tps_pkg::CALC_BITS-1:0]    add_sum;

   logic                             accept, out_free, step, start;
   logic                             emit, emit_last;
   logic [tps_pkg::KIND_BITS-1:0]    emit_kind;
   logic [tps_pkg::ID_BITS-1:0]      emit_id;

   assign req.ready = (state_ff == tps_pkg::ST_IDLE);
   assign accept    = req.valid & req.ready;
   assign out_free  = ~rsp_valid_ff | rsp.ready;
   assign step      = out_free &
                      ((state_ff == tps_pkg::ST_TICK) | (state_ff == tps_pkg::ST_ADD));
   assign start     = accept & ((req.action == tps_pkg::ACT_TICK) |
                      ((req.action == tps_pkg::ACT_ADD) && (req.interval != '0)));
   assign busy      = (state_ff != tps_pkg::ST_IDLE);
   assign add_sum   = tps_pkg::CALC_BITS'(time_ff) + tps_pkg::CALC_BITS'(req.interval);

   assign cell_ctrl.start        = start;
   assign cell_ctrl.step         = step;
   assign cell_ctrl.tick_mode    = (state_ff == tps_pkg::ST_TICK);
   assign cell_ctrl.add_mode     = (state_ff == tps_pkg::ST_ADD);
   assign cell_ctrl.cancel       = accept & (req.action == tps_pkg::ACT_CANCEL);
   assign cell_ctrl.handle       = req.handle;
   assign cell_ctrl.time_now     = time_ff;
   assign cell_ctrl.add_deadline = add_deadline_ff;
   assign cell_ctrl.add_period   = add_period_ff;
   assign cell_ctrl.add_repeats  = add_repeats_ff;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      time_in       = time_ff;
      held_valid_in = held_valid_ff;
      held_id_in    = held_id_ff;
      emit          = 1'b0;
      emit_kind     = tps_pkg::KIND_ADDED;
      emit_id       = '0;
      emit_last     = 1'b0;
      case (state_ff)
         tps_pkg::ST_IDLE: begin
            if (accept) begin
               idx_in        = '0;
               held_valid_in = 1'b0;
               case (req.action)
                  tps_pkg::ACT_TICK: state_in = tps_pkg::ST_TICK;
                  tps_pkg::ACT_ADD: begin
                     state_in = (req.interval == '0) ? tps_pkg::ST_IMM : tps_pkg::ST_ADD;
                  end
                  default: state_in = tps_pkg::ST_IDLE;
               endcase
            end
         end
         tps_pkg::ST_TICK: begin
            if (out_free) begin
               // a new firing releases the one held back, which cannot be last
               if (any_fire) begin
                  if (held_valid_ff) begin
                     emit      = 1'b1;
                     emit_kind = tps_pkg::KIND_FIRED;
                     emit_id   = tps_pkg::ID_BITS'(held_id_ff);
                  end
                  held_valid_in = 1'b1;
                  held_id_in    = idx_ff;
               end
               if (idx_ff == IDX_LAST) begin
                  state_in = tps_pkg::ST_FLUSH;
               end else begin
                  idx_in = idx_ff + tps_pkg::IDX_BITS'(1);
               end
            end
         end
         tps_pkg::ST_ADD: begin
            if (out_free) begin
               if (any_take) begin
                  emit      = 1'b1;
                  emit_kind = tps_pkg::KIND_ADDED;
                  emit_id   = tps_pkg::ID_BITS'(idx_ff);
                  emit_last = 1'b1;
                  state_in  = tps_pkg::ST_IDLE;
               end else if (idx_ff == IDX_LAST) begin
                  emit      = 1'b1;
                  emit_kind = tps_pkg::KIND_FULL;
                  emit_last = 1'b1;
                  state_in  = tps_pkg::ST_IDLE;
               end else begin
                  idx_in = idx_ff + tps_pkg::IDX_BITS'(1);
               end
            end
         end
         tps_pkg::ST_FLUSH: begin
            if (out_free) begin
               if (held_valid_ff) begin
                  emit      = 1'b1;
                  emit_kind = tps_pkg::KIND_FIRED;
                  emit_id   = tps_pkg::ID_BITS'(held_id_ff);
                  emit_last = 1'b1;
               end
               held_valid_in = 1'b0;
               time_in       = time_ff + tps_pkg::TIME_BITS'(1);
               state_in      = tps_pkg::ST_IDLE;
            end
         end
         tps_pkg::ST_IMM: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_kind = tps_pkg::KIND_IMMEDIATE;
               emit_last = 1'b1;
               state_in  = tps_pkg::ST_IDLE;
            end
         end
         default: state_in = tps_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tps_pkg::ST_IDLE;
         idx_ff        <= '0;
         time_ff       <= '0;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         time_ff       <= time_in;
         held_valid_ff <= held_valid_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      held_id_ff <= held_id_in;
      if (accept) begin
         add_deadline_ff <= add_sum[tps_pkg::TIME_BITS-1:0];
         add_period_ff   <= req.interval;
         add_repeats_ff  <= tps_pkg::REPEAT_BITS'(req.repeat_count);
      end
      if (emit) begin
         rsp_kind_ff <= emit_kind;
         rsp_id_ff   <= emit_id;
         rsp_now_ff  <= tps_pkg::NOW_BITS'(time_ff);
         rsp_last_ff <= emit_last;
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.kind     = rsp_kind_ff;
   assign rsp.timer_id = rsp_id_ff;
   assign rsp.now      = rsp_now_ff;
   assign rsp.last     = rsp_last_ff;

endmodule

/* src/timer_pool_scheduler_top.sv */
// ----------------------------------------------------------------------------
// timer_pool_scheduler_top
// Pool of 32 software timers built as a chain of entry cells and a sequencer.
// ----------------------------------------------------------------------------
// Usage: request words (tick, add, cancel) enter on req_if, response words
// (added, fired, fired at once, pool full) leave on rsp_if; both are
// valid/ready channels and a word moves when valid and ready are high.
// A request is taken only while the block is idle, one at a time.
// Cancel gives no word and leaves the block idle. An add with zero interval
// gives its fired-at-once word without a walk. Any other add walks a token
// down the chain one cell per cycle while the output register is free and
// stops at the first free entry. A tick walks the token over all TIMER_SLOTS
// cells, one cell per cycle while the output register is free, then a flush
// step releases the last firing and advances time; the chain scan sets rate.
// Response words pass through one output register; while a word waits there
// with ready low the token stops and the sequence resumes without loss.
// Synchronous reset clears the time counter, all entry valid bits, the token
// and the output register; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module timer_pool_scheduler_top (
   input  logic       clock,
   input  logic       reset,
   tps_req_if.sink    req_if,
   tps_rsp_if.source  rsp_if
);

   tps_pkg::cell_ctrl_type             cell_ctrl;
   tps_pkg::cell_stat_type             cell_stat [tps_pkg::TIMER_SLOTS];
   logic [tps_pkg::TIMER_SLOTS:0]      tok_link;
   logic [tps_pkg::TIMER_SLOTS-1:0]    tok_vec;
   logic [tps_pkg::TIMER_SLOTS-1:0]    fire_vec;
   logic [tps_pkg::TIMER_SLOTS-1:0]    take_vec;
   logic                               any_fire, any_take, busy;

   assign tok_link[0] = cell_ctrl.start;

   for (genvar i = 0; i < tps_pkg::TIMER_SLOTS; i++) begin : g_cell
      tps_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (tps_pkg::IDX_BITS'(i)),
         .ctrl       (cell_ctrl),
         .tok_left   (tok_link[i]),
         .tok_right  (tok_link[i+1]),
         .stat       (cell_stat[i])
      );
      assign tok_vec[i]  = cell_stat[i].tok;
      assign fire_vec[i] = cell_stat[i].fire;
      assign take_vec[i] = cell_stat[i].take;
   end

   // only the cell holding the token can report, so a plain OR selects it
   assign any_fire = |fire_vec;
   assign any_take = |take_vec;

   tps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .any_fire  (any_fire),
      .any_take  (any_take),
      .cell_ctrl (cell_ctrl),
      .busy      (busy)
   );

   `TPS_ASSERT(a_token_single, clock, reset, $onehot0(tok_vec))
   `TPS_ASSERT_IMPL(a_idle_no_token, clock, reset, !busy, tok_vec == '0)
   `TPS_ASSERT_NEXT(a_take_ends_add, clock, reset, cell_ctrl.step && any_take, !busy)

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives tick, add and cancel words into the timer pool scheduler and checks
// every response word against a cycle-free software copy of the timer pool.
// Short directed opening, then random bursts of timer traffic with random
// backpressure on both channels.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [tps_pkg::ACTION_BITS-1:0] ACT_UNUSED = 2'd3;
   localparam int TARGET_REQUESTS = 410;

   typedef struct packed {
      logic [tps_pkg::KIND_BITS-1:0] kind;
      logic [tps_pkg::ID_BITS-1:0]   timer_id;
      logic [tps_pkg::NOW_BITS-1:0]  now;
      logic                          last;
   } timer_event_type;

   // Software copy of the pool; predicts the response words of each request.
   class timer_pool_scoreboard_type;
      bit [tps_pkg::TIME_BITS-1:0]   clock_now;
      bit                            slot_busy[tps_pkg::TIMER_SLOTS];
      bit [tps_pkg::TIME_BITS-1:0]   slot_deadline[tps_pkg::TIMER_SLOTS];
      bit [tps_pkg::PERIOD_BITS-1:0] slot_period[tps_pkg::TIMER_SLOTS];
      bit [tps_pkg::REPEAT_BITS-1:0] slot_left[tps_pkg::TIMER_SLOTS];
      timer_event_type               due_events[$];
      int errors;
      int words_matched;
      int fired_total;
      int added_total;
      int full_total;
      int immediate_total;
      int peak_burst;

      function new();
         clock_now = '0;
         foreach (slot_busy[i]) slot_busy[i] = 1'b0;
         errors = 0;
         words_matched = 0;
         fired_total = 0;
         added_total = 0;
         full_total = 0;
         immediate_total = 0;
         peak_burst = 0;
      endfunction

      function void push_event(logic [tps_pkg::KIND_BITS-1:0] k, int id, bit fin);
         timer_event_type ev;
         ev.kind = k;
         ev.timer_id = tps_pkg::ID_BITS'(id);
         ev.now = tps_pkg::NOW_BITS'(clock_now);
         ev.last = fin;
         due_events = {due_events, ev};
      endfunction

      function int busy_count();
         int n;
         n = 0;
         foreach (slot_busy[i]) if (slot_busy[i]) n++;
         return n;
      endfunction

      function int pick_busy();
         int ids[$];
         foreach (slot_busy[i]) if (slot_busy[i]) ids = {ids, i};
         if (ids.size() == 0) return $urandom_range(tps_pkg::TIMER_SLOTS - 1);
         return ids[$urandom_range(ids.size() - 1)];
      endfunction

      // Returns 1 when the word changes state or gives a response.
      function bit apply_request(logic [tps_pkg::ACTION_BITS-1:0] act,
                                 logic [tps_pkg::INTERVAL_BITS-1:0] ival,
                                 logic [tps_pkg::COUNT_BITS-1:0] reps,
                                 logic [tps_pkg::HANDLE_BITS-1:0] hnd);
         int burst;
         burst = 0;
         case (act)
            tps_pkg::ACT_TICK: begin
               for (int i = 0; i < tps_pkg::TIMER_SLOTS; i++) begin
                  if (slot_busy[i] && slot_deadline[i] == clock_now) begin
                     push_event(tps_pkg::KIND_FIRED, i, 1'b0);
                     burst++;
                     if (slot_left[i] == 1) begin
                        slot_busy[i] = 1'b0;
                     end else begin
                        if (slot_left[i] != 0) slot_left[i]--;
                        slot_deadline[i] = clock_now + tps_pkg::TIME_BITS'(slot_period[i]);
                     end
                  end
               end
               if (burst > 0) due_events[due_events.size() - 1].last = 1'b1;
               fired_total += burst;
               if (burst > peak_burst) peak_burst = burst;
               clock_now++;
               return 1'b1;
            end
            tps_pkg::ACT_ADD: begin
               if (ival == 0) begin
                  push_event(tps_pkg::KIND_IMMEDIATE, 0, 1'b1);
                  immediate_total++;
                  return 1'b1;
               end
               for (int i = 0; i < tps_pkg::TIMER_SLOTS; i++) begin
                  if (!slot_busy[i]) begin
                     slot_busy[i] = 1'b1;
                     slot_deadline[i] = clock_now + tps_pkg::TIME_BITS'(ival);
                     slot_period[i] = tps_pkg::PERIOD_BITS'(ival);
                     slot_left[i] = tps_pkg::REPEAT_BITS'(reps);
                     push_event(tps_pkg::KIND_ADDED, i, 1'b1);
                     added_total++;
                     return 1'b1;
                  end
               end
               push_event(tps_pkg::KIND_FULL, 0, 1'b1);
               full_total++;
               return 1'b1;
            end
            tps_pkg::ACT_CANCEL: begin
               if (hnd < tps_pkg::TIMER_SLOTS && slot_busy[hnd]) begin
                  slot_busy[hnd] = 1'b0;
                  return 1'b1;
               end
               return 1'b0;
            end
            default: return 1'b0;
         endcase
      endfunction

      function void match_event(timer_event_type got);
         timer_event_type want;
         if (due_events.size() == 0) begin
            $error("unexpected word: kind %0d id %0d now %0d last %0b",
                   got.kind, got.timer_id, got.now, got.last);
            errors++;
            return;
         end
         want = due_events.pop_front();
         words_matched++;
         if (got.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, got.kind);
            errors++;
         end
         if (got.timer_id !== want.timer_id) begin
            $error("timer_id: expected %0d, got %0d", want.timer_id, got.timer_id);
            errors++;
         end
         if (got.now !== want.now) begin
            $error("now: expected %0d, got %0d", want.now, got.now);
            errors++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   calm;
   int   requests_done;

   timer_pool_scoreboard_type sb;

   tps_req_if req_bus ();
   tps_rsp_if rsp_bus ();

   timer_pool_scheduler_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus.sink),
      .rsp_if (rsp_bus.source)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   initial begin
      rsp_bus.ready = 1'b0;
   end

   always @(negedge clock) begin
      rsp_bus.ready <= !reset && (calm || $urandom_range(99) >= 20);
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         sb.match_event({rsp_bus.kind, rsp_bus.timer_id, rsp_bus.now, rsp_bus.last});
      end
   end

   task automatic pause_sender(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
   endtask

   task automatic send_request(input logic [tps_pkg::ACTION_BITS-1:0] act,
                               input logic [tps_pkg::INTERVAL_BITS-1:0] ival,
                               input logic [tps_pkg::COUNT_BITS-1:0] reps,
                               input logic [tps_pkg::HANDLE_BITS-1:0] hnd);
      if (!calm && $urandom_range(99) < 20) pause_sender($urandom_range(1, 4));
      @(negedge clock);
      req_bus.valid        <= 1'b1;
      req_bus.action       <= act;
      req_bus.interval     <= ival;
      req_bus.repeat_count <= reps;
      req_bus.handle       <= hnd;
      do @(posedge clock); while (!req_bus.ready);
      void'(sb.apply_request(act, ival, reps, hnd));
      requests_done++;
   endtask

   // Drop valid and hold until every predicted word has arrived.
   task automatic wait_quiet();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (sb.due_events.size() != 0) @(posedge clock);
   endtask

   task automatic send_tick();
      send_request(tps_pkg::ACT_TICK, $urandom,
                   tps_pkg::COUNT_BITS'($urandom_range(16'hFFFF)),
                   tps_pkg::HANDLE_BITS'($urandom_range(tps_pkg::TIMER_SLOTS - 1)));
   endtask

   task automatic timer_burst();
      int adds;
      int ticks;
      int ival;
      adds = $urandom_range(1, 4);
      ticks = $urandom_range(1, 8);
      repeat (adds) begin
         ival = ($urandom_range(7) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
         send_request(tps_pkg::ACT_ADD, tps_pkg::INTERVAL_BITS'(ival),
                      tps_pkg::COUNT_BITS'($urandom_range(0, 3)),
                      tps_pkg::HANDLE_BITS'($urandom_range(tps_pkg::TIMER_SLOTS - 1)));
      end
      repeat (ticks) send_tick();
   endtask

   task automatic cancel_some();
      repeat ($urandom_range(1, 3))
         send_request(tps_pkg::ACT_CANCEL, $urandom,
                      tps_pkg::COUNT_BITS'($urandom_range(16'hFFFF)),
                      tps_pkg::HANDLE_BITS'(sb.pick_busy()));
   endtask

   task automatic noise_burst();
      repeat ($urandom_range(1, 4))
         send_request(tps_pkg::ACTION_BITS'($urandom_range(3)), $urandom,
                      tps_pkg::COUNT_BITS'($urandom_range(16'hFFFF)),
                      tps_pkg::HANDLE_BITS'($urandom_range(tps_pkg::TIMER_SLOTS - 1)));
   endtask

   // Empty the pool, fill every entry with one deadline, overflow once, then
   // tick until the whole pool fires in a single tick.
   task automatic fill_pool();
      int ival;
      for (int i = 0; i < tps_pkg::TIMER_SLOTS; i++)
         if (sb.slot_busy[i])
            send_request(tps_pkg::ACT_CANCEL, '0, '0, tps_pkg::HANDLE_BITS'(i));
      ival = $urandom_range(1, 3);
      repeat (tps_pkg::TIMER_SLOTS + 1)
         send_request(tps_pkg::ACT_ADD, tps_pkg::INTERVAL_BITS'(ival),
                      tps_pkg::COUNT_BITS'(1), '0);
      repeat (ival + 1) send_tick();
   endtask

   initial begin : stimulus
      int choice;
      int next_quiet;
      bit filled;
      sb = new();
      calm = 1'b0;
      requests_done = 0;
      filled = 1'b0;
      next_quiet = 100;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.action = tps_pkg::ACT_TICK;
      req_bus.interval = '0;
      req_bus.repeat_count = '0;
      req_bus.handle = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_request(tps_pkg::ACT_TICK, 0, 0, 0);
      send_request(tps_pkg::ACT_ADD, 0, 0, 0);
      send_request(tps_pkg::ACT_ADD, 1, 1, 0);
      send_request(tps_pkg::ACT_ADD, '1, '1, '1);
      send_request(tps_pkg::ACT_ADD, 2, 0, 0);
      send_request(tps_pkg::ACT_ADD, 3, 2, 0);
      repeat (7) send_request(tps_pkg::ACT_TICK, '1, '1, '1);
      send_request(tps_pkg::ACT_CANCEL, 0, 0, 1);
      send_request(tps_pkg::ACT_CANCEL, 0, 0, 1);
      send_request(tps_pkg::ACT_CANCEL, '1, '1,
                   tps_pkg::HANDLE_BITS'(tps_pkg::TIMER_SLOTS - 1));
      send_request(ACT_UNUSED, '1, '1, '1);
      send_request(tps_pkg::ACT_ADD, 1, 3, 0);
      repeat (4) send_request(tps_pkg::ACT_TICK, 0, 0, 0);
      send_request(tps_pkg::ACT_CANCEL, 0, 0, 2);
      send_request(tps_pkg::ACT_TICK, 0, 0, 0);
      wait_quiet();

      while (requests_done < TARGET_REQUESTS) begin
         calm = (requests_done >= 150 && requests_done < 230);
         if (requests_done >= next_quiet) begin
            wait_quiet();
            next_quiet += 100;
         end
         choice = $urandom_range(99);
         if ((!filled && requests_done >= 200) || choice < 3) begin
            fill_pool();
            filled = 1'b1;
         end else if (choice < 60) begin
            timer_burst();
         end else if (choice < 78) begin
            cancel_some();
         end else begin
            noise_burst();
         end
      end
      calm = 1'b0;

      wait_quiet();
      repeat (tps_pkg::TIMER_SLOTS + 8) @(posedge clock);
      $display("Checked %0d words: %0d added, %0d fired (up to %0d in one tick),",
               sb.words_matched, sb.added_total, sb.fired_total, sb.peak_burst);
      $display("%0d fired at add, %0d pool-full replies, over %0d requests.",
               sb.immediate_total, sb.full_total, requests_done);
      if (sb.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin : watchdog
      #6_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
